### rtl/distinct_prime_factor_counter_top_macros.svh
// assertion macros used by the checker file
`ifndef DISTINCT_PRIME_FACTOR_COUNTER_TOP_MACROS_SVH
`define DISTINCT_PRIME_FACTOR_COUNTER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define DPFC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the following cycle
`define DPFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dpfc_pkg.sv
package dpfc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 16;
  localparam int unsigned COUNT_W         = 3;
  localparam int unsigned OUT_DATA_W      = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = 3'd7;
  localparam logic [COUNT_W-1:0] MIN_COUNT_RESET = 3'd5;
  localparam int unsigned        FIRST_DIVISOR   = 2;

  // saturating increment of the factor count
  function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = (c == COUNT_MAX) ? c : c + 1'b1;
    return r;
  endfunction

endpackage

### rtl/distinct_prime_factor_counter_top.sv
// distinct prime factor counter
// s_axis carries one unsigned value per beat; m_axis returns one beat per value
// holding the number of distinct prime factors and a flag that the count is at
// or above min_prime_count. cfg_valid_i/cfg_data_i write min_prime_count; the
// port is always ready. it must be written only while the block is idle;
// the block itself does not enforce this. the value is factored by trial
// division with divisors 2, 3, 4, ... through a shared restoring divider.
// each divisor tried costs one division, and each repeated factor found costs
// one more division. s_axis_tready is high only between values, so a new value
// is taken only after the last one has been factored.
// the result sits in an output register; while the receiver stalls, the next
// value is accepted and factored and then waits until the register empties.
// reset empties the output, returns to idle and sets min_prime_count to 5.
module distinct_prime_factor_counter_top #(
  parameter int unsigned VALUE_WIDTH = dpfc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [VALUE_WIDTH-1:0] value, zero padded above
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] prime_count, [3] meets_minimum, zero above
  output logic [dpfc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dpfc_pkg::COUNT_W-1:0]        cfg_data_i
);

  import dpfc_pkg::*;

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned SQW = VALUE_WIDTH + 2;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_CHECK     = 3'd1;
  localparam logic [2:0] ST_DIV_START = 3'd2;
  localparam logic [2:0] ST_DIV_WAIT  = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [W-1:0]       n_q, n_d;
  logic [W-1:0]       div_q, div_d;
  logic [SQW-1:0]     sq_q, sq_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               hit_q, hit_d;
  logic [COUNT_W-1:0] min_q;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic               out_meet_q, out_meet_d;

  logic               div_start;
  logic               div_done;
  logic [W-1:0]       div_quo;
  logic [W-1:0]       div_rem;
  logic               in_beat;
  logic               out_free;

  dpfc_divider #(
    .WIDTH(W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (div_q),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    div_d       = div_q;
    sq_d        = sq_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_cnt_d   = out_cnt_q;
    out_meet_d  = out_meet_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          n_d     = s_axis_tdata[W-1:0];
          div_d   = W'(FIRST_DIVISOR);
          sq_d    = SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
          cnt_d   = '0;
          hit_d   = 1'b0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (n_q <= W'(1)) begin
          state_d = ST_DONE;
        end else if (sq_q > {2'b00, n_q}) begin
          // what is left has no factor below its root, so it is prime
          cnt_d   = count_inc(cnt_q);
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            // keep dividing out the same divisor, count it once
            if (!hit_q) begin
              cnt_d = count_inc(cnt_q);
            end
            hit_d   = 1'b1;
            n_d     = div_quo;
            state_d = ST_DIV_START;
          end else begin
            hit_d   = 1'b0;
            div_d   = div_q + 1'b1;
            // (d+1)^2 = d^2 + 2d + 1
            sq_d    = sq_q + {1'b0, div_q, 1'b1};
            state_d = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cnt_d   = cnt_q;
          out_meet_d  = (cnt_q >= min_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      min_q       <= MIN_COUNT_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        min_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    div_q      <= div_d;
    sq_q       <= sq_d;
    cnt_q      <= cnt_d;
    hit_q      <= hit_d;
    out_cnt_q  <= out_cnt_d;
    out_meet_q <= out_meet_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - COUNT_W - 1){1'b0}}, out_meet_q, out_cnt_q};

endmodule

### rtl/dpfc_divider.sv
module dpfc_divider #(
  parameter int unsigned WIDTH = dpfc_pkg::VALUE_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  logic             active_q, active_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dsr_q, dsr_d;
  logic [WIDTH:0]   trial;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    step_d   = step_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    if (start_i) begin
      active_d = 1'b1;
      step_d   = CNT_W'(WIDTH);
      quo_d    = dividend_i;
      rem_d    = '0;
      dsr_d    = divisor_i;
    end else if (active_q) begin
      rem_d  = fits ? WIDTH'(trial - {1'b0, dsr_q}) : trial[WIDTH-1:0];
      quo_d  = {quo_q[WIDTH-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == CNT_W'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### rtl/dpfc_checker.sv
module dpfc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dpfc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  `include "distinct_prime_factor_counter_top_macros.svh"

  // a stalled result beat holds
  `DPFC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata), "stalled result beat changed")

  // an accepted value leaves the block busy in the following cycle
  `DPFC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
                    !s_axis_tready, "input ready right after a value beat")

  // a new result only comes out of a busy cycle
  `DPFC_ASSERT_SAME(a_result_from_busy, $rose(m_axis_tvalid),
                    !$past(s_axis_tready), "result appeared while idle")

endmodule

bind distinct_prime_factor_counter_top dpfc_checker u_dpfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/distinct_prime_factor_counter_top_test.sv
module distinct_prime_factor_counter_top_test;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CW      = dpfc_pkg::COUNT_W;

  typedef struct packed {
    logic [CW-1:0] prime_count;
    logic          meets_minimum;
  } factor_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [VALUE_W-1:0] s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [dpfc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CW-1:0]      cfg_data_i    = '0;

  factor_result_t pending_counts[$];
  logic [CW-1:0]  min_count_setting = dpfc_pkg::MIN_COUNT_RESET;
  int unsigned    mismatch_count    = 0;
  bit             source_gaps       = 1'b1;
  bit             sink_stalls       = 1'b1;

  distinct_prime_factor_counter_top #(
    .VALUE_WIDTH(VALUE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // distinct primes by trial division, saturated to the count width
  function automatic factor_result_t factor_count_of(input logic [VALUE_W-1:0] value);
    int unsigned    rest;
    int unsigned    divisor;
    int unsigned    primes;
    factor_result_t r;
    rest    = 32'(value);
    divisor = 2;
    primes  = 0;
    while (rest > 1) begin
      if (divisor * divisor > rest) begin
        // what is left is a prime
        primes++;
        break;
      end
      if (rest % divisor == 0) begin
        primes++;
        while (rest % divisor == 0) rest = rest / divisor;
      end
      divisor++;
    end
    if (primes > 7) primes = 7;
    r.prime_count   = primes[CW-1:0];
    r.meets_minimum = (r.prime_count >= min_count_setting);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $realtime);
    mismatch_count++;
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] value);
    int unsigned gap;
    s_axis_tdata  <= value;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_counts.push_back(factor_count_of(value));
    gap = source_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_min_count(input logic [CW-1:0] min_count);
    cfg_data_i  <= min_count;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i       <= 1'b0;
    min_count_setting = min_count;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned small_primes [9] = '{2, 3, 5, 7, 11, 13, 17, 19, 23};
    int unsigned product;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) return VALUE_W'($urandom);
    if (kind < 8) return VALUE_W'($urandom_range(0, 255));
    // products of small primes reach the high counts
    product = 1;
    foreach (small_primes[i]) begin
      if ($urandom_range(0, 3) != 0 && product * small_primes[i] <= 65535) begin
        product = product * small_primes[i];
        while ($urandom_range(0, 2) == 0 && product * small_primes[i] <= 65535)
          product = product * small_primes[i];
      end
    end
    return product[VALUE_W-1:0];
  endfunction

  task automatic test_reset_minimum();
    logic [VALUE_W-1:0] corner_values [13] = '{
      16'd0, 16'd1, 16'd2, 16'd4, 16'd49, 16'd210, 16'd2310, 16'd30030,
      16'd65535, 16'd32768, 16'd65521, 16'd63001, 16'd65498
    };
    foreach (corner_values[i]) send_value(corner_values[i]);
    wait_for_results();
  endtask

  task automatic test_minimum_extremes();
    write_min_count(3'd0);
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'd2);
    wait_for_results();
    write_min_count(3'd7);
    send_value(16'd30030);
    send_value(16'd0);
    send_value(16'd60060);
    wait_for_results();
    write_min_count(3'd1);
    send_value(16'd1);
    send_value(16'd65025);
    send_value(16'd3);
    wait_for_results();
  endtask

  task automatic test_random_values();
    for (int phase = 0; phase < 5; phase++) begin
      wait_for_results();
      write_min_count(CW'($urandom_range(0, 7)));
      source_gaps = (phase % 3) != 1;
      sink_stalls = (phase % 3) == 0;
      repeat (20) send_value(pick_value());
    end
    wait_for_results();
  endtask

  // receiver: a stall is drawn per beat and counted from the moment a result waits
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = sink_stalls ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        do @(posedge clk_i); while (!m_axis_tvalid);
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin : result_check
    factor_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_counts.size() == 0) begin
        report_mismatch("unexpected result beat, prime_count", 0, 32'(m_axis_tdata[2:0]));
      end else begin
        want = pending_counts.pop_front();
        if (m_axis_tdata[2:0] !== want.prime_count)
          report_mismatch("prime_count", 32'(want.prime_count), 32'(m_axis_tdata[2:0]));
        if (m_axis_tdata[3] !== want.meets_minimum)
          report_mismatch("meets_minimum", 32'(want.meets_minimum), 32'(m_axis_tdata[3]));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_minimum();
    test_minimum_extremes();
    test_random_values();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/dpfc_pkg.sv
rtl/dpfc_divider.sv
rtl/distinct_prime_factor_counter_top.sv
rtl/dpfc_checker.sv
dv/distinct_prime_factor_counter_top_test.sv
